### hw/rtl/rty_pkg.sv
// Shared constants and types for the RGB to YUV 4:2:0 converter.
package rty_pkg;

    localparam int CFG_W = 13;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic chroma;
        logic frame_end;
    } t_pos;

endpackage

### hw/rtl/rgb_to_yuv420_pixel_converter.sv
// Top level of the RGB to YUV 4:2:0 pixel converter.
// Channel  Dir  Handshake          Word
// pixel    in   i_valid / o_ready  i_red, i_green, i_blue
// yuv      out  o_valid / i_ready  o_luma, o_chroma_u, o_chroma_v, o_chroma_valid, o_frame_end
// config   in   APB psel/penable   paddr, pwdata, prdata
// One word per clock while i_ready holds; the path runs through the input register, then the result register.
// Reset is synchronous: counters return to column 0, row 0, registers to 640 x 480.
// A stalled result holds in the result register; the input register then takes a word only while it is empty.
// Register writes are accepted without wait states and are registered.
module rgb_to_yuv420_pixel_converter #(
    parameter int MAX_WIDTH = rty_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rty_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_red,
    input  logic [7:0]                 i_green,
    input  logic [7:0]                 i_blue,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_luma,
    output logic [7:0]                 o_chroma_u,
    output logic [7:0]                 o_chroma_v,
    output logic                       o_chroma_valid,
    output logic                       o_frame_end,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rty_pkg::ADDR_W-1:0] paddr,
    input  logic [rty_pkg::DATA_W-1:0] pwdata,
    output logic [rty_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [rty_pkg::CFG_W-1:0] r_line_width, r_frame_height;
    logic                      cfg_wr, in_acc, s1_adv;
    logic                      r_s1_v, r_o_v;
    logic [7:0]                r_red, r_green, r_blue;
    rty_pkg::t_pos             pos, r_pos;
    logic [7:0]                luma, cu, cv;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        unique case (paddr[2])
            rty_pkg::REG_LINE_WIDTH:   prdata = rty_pkg::DATA_W'(r_line_width);
            rty_pkg::REG_FRAME_HEIGHT: prdata = rty_pkg::DATA_W'(r_frame_height);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= rty_pkg::LINE_WIDTH_RESET;
            r_frame_height <= rty_pkg::FRAME_HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == rty_pkg::REG_LINE_WIDTH) begin
                r_line_width <= pwdata[rty_pkg::CFG_W-1:0];
            end else begin
                r_frame_height <= pwdata[rty_pkg::CFG_W-1:0];
            end
        end
    end

    assign s1_adv = ~r_o_v | i_ready;
    assign o_ready = ~r_s1_v | s1_adv;
    assign in_acc = i_valid & o_ready;
    assign o_valid = r_o_v;

    rty_pos #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (in_acc),
        .i_line_width  (r_line_width),
        .i_frame_height(r_frame_height),
        .o_pos         (pos)
    );

    rty_csc u_csc (
        .i_red     (r_red),
        .i_green   (r_green),
        .i_blue    (r_blue),
        .i_chroma  (r_pos.chroma),
        .o_luma    (luma),
        .o_chroma_u(cu),
        .o_chroma_v(cv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_v <= i_valid;
            end
            if (s1_adv) begin
                r_o_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_red <= i_red;
            r_green <= i_green;
            r_blue <= i_blue;
            r_pos <= pos;
        end
        if (s1_adv && r_s1_v) begin
            o_luma <= luma;
            o_chroma_u <= cu;
            o_chroma_v <= cv;
            o_chroma_valid <= r_pos.chroma;
            o_frame_end <= r_pos.frame_end;
        end
    end

endmodule

### hw/rtl/rty_pos.sv
// Column and row counters that mark chroma sites and the end of the frame.
module rty_pos #(
    parameter int MAX_WIDTH = rty_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rty_pkg::DEF_MAX_HEIGHT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_advance,
    input  logic [rty_pkg::CFG_W-1:0] i_line_width,
    input  logic [rty_pkg::CFG_W-1:0] i_frame_height,
    output rty_pkg::t_pos            o_pos
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WCL = $clog2(MAX_WIDTH + 1);
    localparam int HCL = $clog2(MAX_HEIGHT + 1);
    localparam int WW = (WCL > rty_pkg::CFG_W) ? WCL : rty_pkg::CFG_W;
    localparam int HW = (HCL > rty_pkg::CFG_W) ? HCL : rty_pkg::CFG_W;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [WW-1:0] w_lim, col_inc;
    logic [HW-1:0] h_lim, row_inc;
    logic          last_col, last_row;

    always_comb begin
        if (i_line_width == '0) begin
            w_lim = WW'(1);
        end else if (WW'(i_line_width) > WW'(MAX_WIDTH)) begin
            w_lim = WW'(MAX_WIDTH);
        end else begin
            w_lim = WW'(i_line_width);
        end
        if (i_frame_height == '0) begin
            h_lim = HW'(1);
        end else if (HW'(i_frame_height) > HW'(MAX_HEIGHT)) begin
            h_lim = HW'(MAX_HEIGHT);
        end else begin
            h_lim = HW'(i_frame_height);
        end
        col_inc = WW'(r_col) + WW'(1);
        row_inc = HW'(r_row) + HW'(1);
        last_col = col_inc >= w_lim;
        last_row = row_inc >= h_lim;
        o_pos.chroma = ~r_col[0] & ~r_row[0];
        o_pos.frame_end = last_col & last_row;
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

### hw/rtl/rty_csc.sv
// BT.601 color conversion of one pixel to luma and optional chroma.
module rty_csc (
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic       i_chroma,
    output logic [7:0] o_luma,
    output logic [7:0] o_chroma_u,
    output logic [7:0] o_chroma_v
);

    logic        [15:0] sum_y;
    logic signed [16:0] sr, sg, sb, sum_u, sum_v, q_u, q_v;
    logic        [8:0]  q_y;

    function automatic logic [7:0] clamp8(input logic signed [16:0] q);
        logic [7:0] res;
        if (q < 17'sd0) begin
            res = 8'd0;
        end else if (q > 17'sd255) begin
            res = 8'd255;
        end else begin
            res = q[7:0];
        end
        return res;
    endfunction

    always_comb begin
        sum_y = 16'd33 * {8'd0, i_red} + 16'd65 * {8'd0, i_green}
              + 16'd13 * {8'd0, i_blue};
        q_y = {1'b0, sum_y[14:7]} + 9'd16;
        o_luma = (q_y > 9'd255) ? 8'd255 : q_y[7:0];

        sr = $signed({9'd0, i_red});
        sg = $signed({9'd0, i_green});
        sb = $signed({9'd0, i_blue});
        sum_u = -17'sd38 * sr - 17'sd74 * sg + 17'sd112 * sb;
        sum_v = 17'sd112 * sr - 17'sd94 * sg - 17'sd18 * sb;
        q_u = (sum_u >>> 8) + 17'sd128;
        q_v = (sum_v >>> 8) + 17'sd128;
        o_chroma_u = i_chroma ? clamp8(q_u) : 8'd0;
        o_chroma_v = i_chroma ? clamp8(q_v) : 8'd0;
    end

endmodule

### hw/rtl/rty_checker.sv
// Port-level checks for the RGB to YUV 4:2:0 converter, bound to the top level.
module rty_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_luma,
    input logic [7:0] o_chroma_u,
    input logic [7:0] o_chroma_v,
    input logic       o_chroma_valid,
    input logic       o_frame_end,
    input logic       pready
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_no_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_chroma_valid |-> o_chroma_u == 8'd0 && o_chroma_v == 8'd0)
        else $error("chroma not zero off chroma site");

    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_luma >= 8'd16 && o_luma <= 8'd237)
        else $error("luma out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_luma) && $stable(o_chroma_u)
            && $stable(o_chroma_v) && $stable(o_chroma_valid) && $stable(o_frame_end))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind rgb_to_yuv420_pixel_converter rty_checker u_rty_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_luma        (o_luma),
    .o_chroma_u    (o_chroma_u),
    .o_chroma_v    (o_chroma_v),
    .o_chroma_valid(o_chroma_valid),
    .o_frame_end   (o_frame_end),
    .pready        (pready)
);
